FILE: rtl/rmc_pkg.sv
package rmc_pkg;

  localparam int unsigned TableSlotsDefault = 16;
  localparam int unsigned FrontSlotsDefault = 8;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned HandleW = 48;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned FrontShift = 12;
  localparam logic [SizeW-1:0] StackRegionBytes = 32'h0001_0000;

  localparam logic [CfgIdxW-1:0] CfgGlobalCap  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrontCap   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFrontEn    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgStackEn    = 2'd3;

  localparam logic [1:0] LvlNone  = 2'd0;
  localparam logic [1:0] LvlFront = 2'd1;
  localparam logic [1:0] LvlStack = 2'd2;
  localparam logic [1:0] LvlTable = 2'd3;

  localparam logic MODE_TAKE = 1'b0;

  typedef struct packed {
    logic               mode;
    logic [SizeW-1:0]   req_size;
    logic [HandleW-1:0] handle_in;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [HandleW-1:0] handle_out;
    logic [1:0]         level;
    logic [SizeW-1:0]   held_bytes;
  } rsp_t;

  typedef struct packed {
    logic [SizeW-1:0] global_cap;
    logic [SizeW-1:0] front_cap;
    logic             front_en;
    logic             stack_en;
  } cfg_t;

  function automatic logic [SizeW-1:0] sat_sub(logic [SizeW-1:0] a, logic [SizeW-1:0] b);
    sat_sub = (a >= b) ? (a - b) : '0;
  endfunction

endpackage

FILE: rtl/rmc_if.sv
interface rmc_req_if;
  logic          valid;
  logic          ready;
  rmc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rmc_rsp_if;
  logic          valid;
  logic          ready;
  rmc_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/retained_mapping_cache.sv
// Retained region cache.
// Input channel req carries mode (take/put), req_size and handle_in; output
// channel rsp returns hit, handle_out, level and held_bytes, one response per
// transaction, in order. Registers are written through cfg_we_i/cfg_idx_i/
// cfg_data_i: 0 global byte cap, 1 front byte cap, 2 front enable, 3 stack enable.
// One request is handled at a time: accept, read the front store and stack
// memories, scan the slot table one slot a cycle, then update and respond.
// The slot scan, which grows with TABLE_SLOTS, sets the time from accept to
// response. A new request is accepted only once the previous response is valid.
// Reset empties all levels, zeroes the byte totals and restores the register
// defaults (64 MiB, 1 MiB, enabled, enabled). A stalled receiver holds the
// response; the next request is still accepted and scanned, then waits at its
// update step until the held response drains, and no further request is taken.
module retained_mapping_cache #(
  parameter int unsigned TABLE_SLOTS = rmc_pkg::TableSlotsDefault,
  parameter int unsigned FRONT_SLOTS = rmc_pkg::FrontSlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rmc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rmc_pkg::CfgDataW-1:0]  cfg_data_i,
  rmc_req_if.sink                       req,
  rmc_rsp_if.source                     rsp
);
  import rmc_pkg::*;

  cfg_t cfg;

  rmc_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  rmc_core #(.TableSlots(TABLE_SLOTS), .FrontSlots(FRONT_SLOTS)) u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .req(req), .rsp(rsp)
  );
endmodule

FILE: rtl/rmc_cfg.sv
module rmc_cfg (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [rmc_pkg::CfgIdxW-1:0]            cfg_idx_i,
  input  logic [rmc_pkg::CfgDataW-1:0]           cfg_data_i,
  output rmc_pkg::cfg_t                          cfg_o
);
  import rmc_pkg::*;

  cfg_t cfg_q;

  // Capture register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.global_cap <= 32'd67108864;
      cfg_q.front_cap  <= 32'd1048576;
      cfg_q.front_en   <= 1'b1;
      cfg_q.stack_en   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGlobalCap: cfg_q.global_cap <= cfg_data_i;
        CfgFrontCap:  cfg_q.front_cap  <= cfg_data_i;
        CfgFrontEn:   cfg_q.front_en   <= cfg_data_i[0];
        CfgStackEn:   cfg_q.stack_en   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

FILE: rtl/rmc_core.sv
module rmc_core #(
  parameter int unsigned TableSlots = rmc_pkg::TableSlotsDefault,
  parameter int unsigned FrontSlots = rmc_pkg::FrontSlotsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rmc_pkg::cfg_t  cfg_i,
  rmc_req_if.sink        req,
  rmc_rsp_if.source      rsp
);
  import rmc_pkg::*;

  localparam int unsigned TIdxW = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam int unsigned FIdxW = (FrontSlots > 1) ? $clog2(FrontSlots) : 1;
  localparam int unsigned CntW  = $clog2(TableSlots + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DONE  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  // Front store and stack memories: one entry per word, registered read
  logic [HandleW+SizeW-1:0] front_mem [FrontSlots];
  logic [HandleW-1:0]       stack_mem [TableSlots];
  logic [HandleW+SizeW-1:0] front_rd_q;
  logic [HandleW-1:0]       stack_rd_q;
  // Slot table in flip-flops with valid bits; scanned one slot a cycle
  logic [HandleW-1:0]       tbl_h_q [TableSlots];
  logic [SizeW-1:0]         tbl_s_q [TableSlots];
  logic [TableSlots-1:0]    tbl_v_q;
  logic [FrontSlots-1:0]    front_v_q;

  state_e               state_q;
  req_t                 req_q;
  rsp_t                 rsp_q;
  rsp_t                 rsp_d;
  logic                 rsp_valid_q;
  logic [CntW-1:0]      stack_cnt_q;
  logic [SizeW-1:0]     global_held_q, front_held_q;
  logic [TIdxW-1:0]     scan_q;
  logic                 found_q;
  logic [TIdxW-1:0]     found_idx_q;
  logic [FIdxW-1:0]     fidx;
  logic [TIdxW-1:0]     sp_idx;

  if (FrontSlots > 1) begin : g_fi
    assign fidx = FIdxW'((req_q.req_size >> FrontShift) % FrontSlots);
  end else begin : g_fi1
    assign fidx = '0;
  end
  assign sp_idx = (req_q.mode == MODE_TAKE) ? TIdxW'(stack_cnt_q - CntW'(1))
                                            : TIdxW'(stack_cnt_q);

  // Accept a new request while the previous response still waits
  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_q;

  // Memory read ports
  always_ff @(posedge clk_i) begin
    front_rd_q <= front_mem[fidx];
    stack_rd_q <= stack_mem[sp_idx];
  end

  logic front_hit, front_free, stack_take, stack_put, put_ok, glob_ok;
  logic [SizeW-1:0] sz;
  assign sz = req_q.req_size;
  assign front_hit = cfg_i.front_en && front_v_q[fidx] && front_rd_q[SizeW-1:0] == sz;
  assign front_free = cfg_i.front_en && sz <= cfg_i.front_cap &&
                      front_held_q <= cfg_i.front_cap - sz && !front_v_q[fidx];
  assign stack_take = cfg_i.stack_en && sz == StackRegionBytes && stack_cnt_q != '0;
  assign stack_put  = cfg_i.stack_en && sz == StackRegionBytes &&
                      stack_cnt_q < CntW'(TableSlots);
  assign put_ok  = req_q.handle_in != '0 && sz != '0 && sz <= cfg_i.global_cap;
  assign glob_ok = global_held_q <= cfg_i.global_cap - sz;

  // Scan step match for one table slot
  logic scan_match;
  assign scan_match = (req_q.mode == MODE_TAKE)
                    ? (tbl_v_q[scan_q] && tbl_s_q[scan_q] == sz)
                    : !tbl_v_q[scan_q];

  // Build the response for the current request
  always_comb begin
    rsp_d = '0;
    rsp_d.held_bytes = global_held_q;
    if (req_q.mode == MODE_TAKE) begin
      if (front_hit) begin
        rsp_d.hit = 1'b1;
        rsp_d.handle_out = front_rd_q[HandleW+SizeW-1:SizeW];
        rsp_d.level = LvlFront;
      end else if (stack_take) begin
        rsp_d.hit = 1'b1;
        rsp_d.handle_out = stack_rd_q;
        rsp_d.level = LvlStack;
        rsp_d.held_bytes = sat_sub(global_held_q, sz);
      end else if (found_q) begin
        rsp_d.hit = 1'b1;
        rsp_d.handle_out = tbl_h_q[found_idx_q];
        rsp_d.level = LvlTable;
        rsp_d.held_bytes = sat_sub(global_held_q, sz);
      end
    end else if (put_ok) begin
      if (front_free) begin
        rsp_d.hit = 1'b1;
        rsp_d.level = LvlFront;
      end else if (glob_ok && (stack_put || found_q)) begin
        rsp_d.hit = 1'b1;
        rsp_d.held_bytes = global_held_q + sz;
        rsp_d.level = stack_put ? LvlStack : LvlTable;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && req_q.mode != MODE_TAKE && put_ok) begin
      if (front_free) front_mem[fidx] <= {req_q.handle_in, sz};
      else if (glob_ok && stack_put) stack_mem[sp_idx] <= req_q.handle_in;
    end
    if (state_q == S_DONE && req_q.mode != MODE_TAKE && put_ok && !front_free &&
        glob_ok && !stack_put && found_q) begin
      tbl_h_q[found_idx_q] <= req_q.handle_in;
      tbl_s_q[found_idx_q] <= sz;
    end
  end

  // Sequence: latch, read memories, scan table, update and respond
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rsp_valid_q <= 1'b0;
      stack_cnt_q <= '0;
      global_held_q <= '0;
      front_held_q <= '0;
      tbl_v_q <= '0;
      front_v_q <= '0;
      scan_q <= '0;
      found_q <= 1'b0;
      found_idx_q <= '0;
      req_q <= '0;
      rsp_q <= '0;
    end else begin
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (req.valid && req.ready) begin
          req_q <= req.data;
          state_q <= S_READ;
        end
        S_READ: begin
          found_q <= 1'b0;
          scan_q <= (req_q.mode == MODE_TAKE) ? TIdxW'(TableSlots - 1) : '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_match && !found_q) begin
            found_q <= 1'b1;
            found_idx_q <= scan_q;
          end
          if (req_q.mode == MODE_TAKE) begin
            if (scan_q == '0) state_q <= S_DONE;
            else scan_q <= scan_q - TIdxW'(1);
          end else begin
            if (scan_q == TIdxW'(TableSlots - 1)) state_q <= S_DONE;
            else scan_q <= scan_q + TIdxW'(1);
          end
        end
        // Hold here until the previous response has drained
        S_DONE: if (!rsp_valid_q) begin
          rsp_q <= rsp_d;
          if (req_q.mode == MODE_TAKE) begin
            if (front_hit) begin
              front_v_q[fidx] <= 1'b0;
              front_held_q <= sat_sub(front_held_q, sz);
            end else if (stack_take) begin
              stack_cnt_q <= stack_cnt_q - CntW'(1);
              global_held_q <= sat_sub(global_held_q, sz);
            end else if (found_q) begin
              tbl_v_q[found_idx_q] <= 1'b0;
              global_held_q <= sat_sub(global_held_q, sz);
            end
          end else begin
            if (put_ok) begin
              if (front_free) begin
                front_v_q[fidx] <= 1'b1;
                front_held_q <= front_held_q + sz;
              end else if (glob_ok && (stack_put || found_q)) begin
                global_held_q <= global_held_q + sz;
                if (stack_put) begin
                  stack_cnt_q <= stack_cnt_q + CntW'(1);
                end else begin
                  tbl_v_q[found_idx_q] <= 1'b1;
                end
              end
            end
          end
          state_q <= S_OUT;
        end
        S_OUT: if (!rsp_valid_q) begin
          rsp_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: bench/tb.sv
module tb;
  import rmc_pkg::*;

  localparam int unsigned TS = TableSlotsDefault;
  localparam int unsigned FS = FrontSlotsDefault;
  localparam logic MODE_PUT = ~MODE_TAKE;
  localparam int unsigned PHASES = 11;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned DRAIN_CYCLES = 30;

  typedef struct {
    logic               mode;
    logic [SizeW-1:0]   size;
    logic [HandleW-1:0] handle;
    bit                 typed;
    logic               hit;
    logic [HandleW-1:0] handle_out;
    logic [1:0]         level;
    logic [SizeW-1:0]   held;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rmc_req_if req_ch();
  rmc_rsp_if rsp_ch();

  retained_mapping_cache dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the cache contents and registers
  logic [HandleW-1:0] tbl_handle [TS];
  logic [SizeW-1:0]   tbl_size   [TS];
  logic [HandleW-1:0] lifo_handle [TS];
  int unsigned        lifo_depth;
  logic [HandleW-1:0] frt_handle [FS];
  logic [SizeW-1:0]   frt_size   [FS];
  logic [SizeW-1:0]   held_total;
  logic [SizeW-1:0]   frt_total;
  logic [SizeW-1:0]   glob_cap;
  logic [SizeW-1:0]   frt_cap;
  logic               frt_on;
  logic               lifo_on;

  rsp_t     pending_rsp [$];
  dir_row_t dir_pending [$];
  logic [SizeW-1:0] stored_sizes [$];
  int errors = 0;
  int n_rsp = 0;
  int level_hits [4] = '{0, 0, 0, 0};
  int n_miss = 0;
  bit calm = 1'b0;
  bit long_hold_done = 1'b0;

  function automatic void mirror_reset();
    for (int i = 0; i < TS; i++) begin
      tbl_handle[i] = '0;
      tbl_size[i] = '0;
      lifo_handle[i] = '0;
    end
    for (int i = 0; i < FS; i++) begin
      frt_handle[i] = '0;
      frt_size[i] = '0;
    end
    lifo_depth = 0;
    held_total = '0;
    frt_total = '0;
    glob_cap = 32'd67108864;
    frt_cap = 32'd1048576;
    frt_on = 1'b1;
    lifo_on = 1'b1;
  endfunction

  // Apply one take or put to the mirror and return the response it yields
  function automatic rsp_t cache_apply(req_t r);
    rsp_t res;
    int unsigned fi;
    bit done;
    res = '0;
    done = 1'b0;
    fi = (r.req_size >> FrontShift) % FS;
    if (r.mode == MODE_TAKE) begin
      if (frt_on && frt_handle[fi] != 0 && frt_size[fi] == r.req_size) begin
        res.handle_out = frt_handle[fi];
        frt_handle[fi] = '0;
        frt_size[fi] = '0;
        frt_total = (frt_total >= r.req_size) ? frt_total - r.req_size : '0;
        res.hit = 1'b1;
        res.level = LvlFront;
      end else if (lifo_on && r.req_size == StackRegionBytes && lifo_depth != 0) begin
        lifo_depth--;
        res.handle_out = lifo_handle[lifo_depth];
        held_total = (held_total >= r.req_size) ? held_total - r.req_size : '0;
        res.hit = 1'b1;
        res.level = LvlStack;
      end else begin
        for (int i = TS - 1; i >= 0; i--) begin
          if (!done && tbl_handle[i] != 0 && tbl_size[i] == r.req_size) begin
            res.handle_out = tbl_handle[i];
            tbl_handle[i] = '0;
            tbl_size[i] = '0;
            held_total = (held_total >= r.req_size) ? held_total - r.req_size : '0;
            res.hit = 1'b1;
            res.level = LvlTable;
            done = 1'b1;
          end
        end
      end
    end else if (r.handle_in != 0 && r.req_size != 0 && r.req_size <= glob_cap) begin
      if (frt_on && r.req_size <= frt_cap && frt_total <= frt_cap - r.req_size &&
          frt_handle[fi] == 0) begin
        frt_handle[fi] = r.handle_in;
        frt_size[fi] = r.req_size;
        frt_total = frt_total + r.req_size;
        res.hit = 1'b1;
        res.level = LvlFront;
      end else if (held_total <= glob_cap - r.req_size) begin
        if (lifo_on && r.req_size == StackRegionBytes && lifo_depth < TS) begin
          lifo_handle[lifo_depth] = r.handle_in;
          lifo_depth++;
          held_total = held_total + r.req_size;
          res.hit = 1'b1;
          res.level = LvlStack;
        end else begin
          for (int i = 0; i < TS; i++) begin
            if (!done && tbl_handle[i] == 0) begin
              tbl_handle[i] = r.handle_in;
              tbl_size[i] = r.req_size;
              held_total = held_total + r.req_size;
              res.hit = 1'b1;
              res.level = LvlTable;
              done = 1'b1;
            end
          end
        end
      end
    end
    res.held_bytes = held_total;
    return res;
  endfunction

  // Predict on request accept, compare on response accept
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    dir_row_t row;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        want = cache_apply(req_ch.data);
        if (dir_pending.size() != 0) begin
          row = dir_pending.pop_front();
          if (row.typed) begin
            want.hit = row.hit;
            want.handle_out = row.handle_out;
            want.level = row.level;
            want.held_bytes = row.held;
          end
        end
        pending_rsp.push_back(want);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        n_rsp++;
        if (pending_rsp.size() == 0) begin
          $error("unexpected response transaction: %p", got);
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            errors++;
          end
          if (got.handle_out !== want.handle_out) begin
            $error("handle_out: expected %h, actual %h", want.handle_out, got.handle_out);
            errors++;
          end
          if (got.level !== want.level) begin
            $error("level: expected %0d, actual %0d", want.level, got.level);
            errors++;
          end
          if (got.held_bytes !== want.held_bytes) begin
            $error("held_bytes: expected %0d, actual %0d", want.held_bytes, got.held_bytes);
            errors++;
          end
          if (want.hit) level_hits[want.level]++;
          else n_miss++;
        end
      end
    end
  end

  // Response side: random stalls plus one long hold-off to back up the input
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && n_rsp >= 300) begin
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  // Offer one transaction, with an optional idle burst first
  task automatic send_req(req_t r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_rsp.size() != 0);
    repeat (TS + 8) @(posedge clk_i);
  endtask

  // Write all four registers in consecutive cycles
  task automatic write_regs(logic [31:0] gcap, logic [31:0] fcap, logic fen, logic sen);
    logic [31:0] vals [4];
    logic [CfgIdxW-1:0] idx [4];
    vals = '{gcap, fcap, {31'd0, fen}, {31'd0, sen}};
    idx = '{CfgGlobalCap, CfgFrontCap, CfgFrontEn, CfgStackEn};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    glob_cap = gcap;
    frt_cap = fcap;
    frt_on = fen;
    lifo_on = sen;
  endtask

  function automatic logic [31:0] pick_cap(logic [31:0] a, logic [31:0] b);
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return a;
      3: return b;
      default: return $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [SizeW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return StackRegionBytes;
    if (r < 80) return 32'd4096 * $urandom_range(1, 24);
    if (r < 90 && stored_sizes.size() != 0)
      return stored_sizes[$urandom_range(0, stored_sizes.size() - 1)];
    if (r < 96) return $urandom;
    return '0;
  endfunction

  dir_row_t dir_tab [20] = '{
    '{MODE_TAKE, 32'd0, 48'd0, 1'b1, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_PUT, 32'd4096, 48'd0, 1'b1, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_PUT, 32'd0, 48'd1, 1'b1, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_PUT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_PUT, 32'd4096, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 48'd0, LvlFront, 32'd0},
    '{MODE_TAKE, 32'd4096, 48'd0, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, LvlFront, 32'd0},
    '{MODE_PUT, StackRegionBytes, 48'h10, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_PUT, StackRegionBytes, 48'h20, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_PUT, StackRegionBytes, 48'h30, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_TAKE, StackRegionBytes, 48'd0, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_TAKE, StackRegionBytes, 48'd0, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_PUT, 32'd8192, 48'h40, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_PUT, 32'd8192, 48'h50, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_PUT, 32'd8192, 48'h50, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_TAKE, 32'd8192, 48'd0, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_TAKE, 32'd8192, 48'd0, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_TAKE, 32'd8192, 48'd0, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_TAKE, StackRegionBytes, 48'd0, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_TAKE, StackRegionBytes, 48'd0, 1'b0, 1'b0, 48'd0, LvlNone, 32'd0},
    '{MODE_PUT, 32'h0400_0001, 48'h1234, 1'b1, 1'b0, 48'd0, LvlNone, 32'd0}
  };

  // Main sequence
  initial begin
    req_t r;
    logic [HandleW-1:0] last_handle;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    mirror_reset();
    last_handle = 48'h1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    foreach (dir_tab[i]) begin
      r.mode = dir_tab[i].mode;
      r.req_size = dir_tab[i].size;
      r.handle_in = dir_tab[i].handle;
      dir_pending.push_back(dir_tab[i]);
      send_req(r);
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: write_regs(32'd67108864, 32'd1048576, 1'b1, 1'b1);
        1: write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
        2: write_regs(32'd0, 32'd0, 1'b1, 1'b0);
        3: write_regs(32'd196608, 32'd16384, 1'b1, 1'b1);
        default: write_regs(pick_cap(32'd196608, 32'd67108864),
                            pick_cap(32'd8192, 32'd40000),
                            $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
      endcase
      if (p == PHASES - 1) calm = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r.mode = ($urandom_range(0, 1) == 0) ? MODE_TAKE : MODE_PUT;
        r.req_size = pick_size();
        case ($urandom_range(0, 19))
          0: r.handle_in = '0;
          1: r.handle_in = last_handle;
          default: r.handle_in = {16'($urandom), 32'($urandom)};
        endcase
        if (r.mode == MODE_PUT) begin
          last_handle = r.handle_in;
          if (stored_sizes.size() > 32) void'(stored_sizes.pop_front());
          stored_sizes.push_back(r.req_size);
        end
        send_req(r);
      end
    end

    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_rsp.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d responses over %0d register settings", n_rsp, PHASES);
    $display("hits front %0d, stack %0d, table %0d; misses or refusals %0d",
             level_hits[LvlFront], level_hits[LvlStack], level_hits[LvlTable], n_miss);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("retained_mapping_cache: match");
    end else begin
      $display("retained_mapping_cache: mismatch");
    end
    $finish;
  end

  // Hard stop if the handshake hangs
  initial begin
    #5000000;
    $display("retained_mapping_cache: mismatch");
    $finish;
  end

endmodule
